@@ sv/fspt_pkg.sv @@
// Shared types and constants for the frame sync peak tracker.
// Used by fspt_ctrl, fspt_dpath and frame_sync_peak_tracker; no dependencies.
`default_nettype none

package fspt_pkg;

   // Symbols per frame after reset
   localparam logic [5:0] SPF_RESET = 6'd15;

   // Most negative Q16.16 metric, the value of an empty history entry
   localparam logic signed [31:0] METRIC_MIN = 32'sh8000_0000;

   // CSR register indexes
   localparam logic CSR_SPF    = 1'b0;
   localparam logic CSR_SYNCED = 1'b1;

   typedef enum logic [1:0] {
      LIGHT_NONE   = 2'd0,
      LIGHT_GREEN  = 2'd1,
      LIGHT_YELLOW = 2'd2,
      LIGHT_RED    = 2'd3
   } light_type;

   typedef struct packed {
      logic               mode;
      logic               acquire;
      logic signed [31:0] corr_metric;
   } req_type;

   typedef struct packed {
      logic [4:0] symbol_id;
      logic       id_changed;
      logic [1:0] sync_light;
      logic       ship_data;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;
      logic start;
      logic green;
      logic push;
      logic scan_init;
      logic scan_step;
      logic eval;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mode;
      logic bypass;
      logic fill_zero;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/fspt_ctrl.sv @@
// Sequencer of the frame sync peak tracker: accepts items and steps the datapath.
// Depends on fspt_pkg for the command and status structs.
`default_nettype none

module fspt_ctrl
   import fspt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   assign req_ready = ready_ff;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
               ready_in  = 1'b0;
            end
         end
         ST_DECIDE: begin
            if (status.mode) begin
               cmd.start = 1'b1;
               state_in  = ST_IDLE;
               ready_in  = 1'b1;
            end else if (status.bypass) begin
               cmd.green = 1'b1;
               state_in  = ST_FIN;
            end else begin
               cmd.push = 1'b1;
               state_in = status.fill_zero ? ST_SETUP : ST_FIN;
            end
         end
         ST_SETUP: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read compares at the end of this cycle
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
               ready_in     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/fspt_dpath.sv @@
// Datapath of the frame sync peak tracker: CSRs, metric history memory,
// peak scan, sync decision and result register. Depends on fspt_pkg.
`default_nettype none

module fspt_dpath
   import fspt_pkg::*;
#(
   parameter int MAX_SYMBOLS = 32
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_data,
   input  wire req_type    req_data,
   input  wire cmd_type    cmd,
   output status_type      status,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   localparam int AW = $clog2(MAX_SYMBOLS);
   localparam int NW = AW + 1;
   localparam int FW = (NW > 4) ? NW : 4;

   // CSRs
   logic [5:0]  spf_ff, spf_in;
   logic        synced_ff, synced_in;

   // item and tracking state
   req_type     item_ff;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic        first_ff, first_in;
   logic        bad_ff, bad_in;
   logic        good_ff, good_in;
   light_type   light_ff, light_in;
   logic        changed_ff, changed_in;

   // history: circular buffer of n entries, oldest at wp
   logic signed [31:0]   hist_mem [MAX_SYMBOLS];
   logic [MAX_SYMBOLS-1:0] vld_ff, vld_in;
   logic [AW-1:0] wp_ff, wp_in;

   // scan
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] rd_idx_ff;
   logic          rd_en_ff;
   logic          rd_vld_ff;
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] best_ff;
   logic [AW-1:0]      peak_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   logic [NW-1:0] n_len;
   logic [NW-1:0] n_last;
   logic [NW-1:0] mid;
   logic [NW-1:0] mid_tgt;
   logic [NW-1:0] first_tgt;
   logic          peak_is_mid;
   logic          cnt_is_mid;
   logic          cnt_wrap;
   logic signed [31:0] rd_val;
   logic [AW-1:0] wp_next;
   logic [AW-1:0] ptr_next;

   // frame length saturated to 2..MAX_SYMBOLS
   always_comb begin
      if (spf_ff < 6'd2) begin
         n_len = NW'(2);
      end else if ({1'b0, spf_ff} > 7'(MAX_SYMBOLS)) begin
         n_len = NW'(MAX_SYMBOLS);
      end else begin
         n_len = NW'(spf_ff);
      end
   end

   assign n_last      = n_len - NW'(1);
   assign mid         = n_len >> 1;
   assign mid_tgt     = n_len - mid - NW'(1);
   assign first_tgt   = n_len - {1'b0, peak_ff} - NW'(1);
   assign peak_is_mid = ({1'b0, peak_ff} == mid);
   assign cnt_is_mid  = ({1'b0, cnt_ff} == mid_tgt);
   assign cnt_wrap    = ({1'b0, cnt_ff} == n_last);
   assign wp_next     = ({1'b0, wp_ff} == n_last) ? '0 : wp_ff + AW'(1);
   assign ptr_next    = ({1'b0, ptr_ff} == n_last) ? '0 : ptr_ff + AW'(1);
   assign rd_val      = rd_vld_ff ? rd_data_ff : METRIC_MIN;

   assign status.mode      = item_ff.mode;
   assign status.bypass    = synced_ff || !item_ff.acquire;
   assign status.fill_zero = (fill_ff == '0);
   assign status.scan_last = ({1'b0, k_ff} == n_last);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      spf_in       = spf_ff;
      synced_in    = synced_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      first_in     = first_ff;
      bad_in       = bad_ff;
      good_in      = good_ff;
      light_in     = light_ff;
      changed_in   = changed_ff;
      vld_in       = vld_ff;
      wp_in        = wp_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         case (csr_index)
            CSR_SPF: begin
               spf_in = csr_data;
               cnt_in = '0;
               vld_in = '0;
               wp_in  = '0;
            end
            CSR_SYNCED: begin
               synced_in = csr_data[0];
            end
            default: begin
               synced_in = synced_ff;
            end
         endcase
      end

      if (cmd.latch) begin
         light_in   = LIGHT_NONE;
         changed_in = 1'b0;
      end

      if (cmd.start) begin
         cnt_in   = '0;
         vld_in   = '0;
         wp_in    = '0;
         bad_in   = 1'b1;
         first_in = 1'b1;
         good_in  = 1'b0;
         fill_in  = FW'(n_len);
      end

      if (cmd.green) begin
         light_in = LIGHT_GREEN;
      end

      if (cmd.push) begin
         vld_in[wp_ff] = 1'b1;
         wp_in         = wp_next;
         if (fill_ff != '0) begin
            fill_in = fill_ff - FW'(1);
         end
      end

      if (cmd.scan_init) begin
         ptr_in = wp_ff;
         k_in   = '0;
      end

      if (cmd.scan_step) begin
         ptr_in = ptr_next;
         k_in   = k_ff + AW'(1);
      end

      if (cmd.eval) begin
         if (first_ff) begin
            first_in = 1'b0;
            cnt_in   = AW'(first_tgt);
         end else if (peak_is_mid) begin
            if (cnt_is_mid) begin
               bad_in   = 1'b0;
               good_in  = 1'b1;
               light_in = LIGHT_GREEN;
            end else begin
               if (bad_ff) begin
                  cnt_in     = AW'(mid_tgt);
                  changed_in = 1'b1;
                  bad_in     = 1'b0;
                  light_in   = LIGHT_RED;
               end else begin
                  bad_in   = 1'b1;
                  light_in = good_ff ? LIGHT_YELLOW : LIGHT_RED;
               end
               good_in = 1'b0;
            end
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         // advance the symbol counter as the id is loaded into the result register
         cnt_in       = cnt_wrap ? '0 : cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spf_ff       <= SPF_RESET;
         synced_ff    <= 1'b0;
         cnt_ff       <= '0;
         fill_ff      <= FW'(SPF_RESET);
         first_ff     <= 1'b1;
         bad_ff       <= 1'b1;
         good_ff      <= 1'b0;
         vld_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rd_en_ff     <= 1'b0;
      end else begin
         spf_ff       <= spf_in;
         synced_ff    <= synced_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         first_ff     <= first_in;
         bad_ff       <= bad_in;
         good_ff      <= good_in;
         vld_ff       <= vld_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_en_ff     <= cmd.scan_step;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      light_ff   <= light_in;
      changed_ff <= changed_in;
      ptr_ff     <= ptr_in;
      k_ff       <= k_in;
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      rd_idx_ff <= k_ff;
      rd_vld_ff <= vld_ff[ptr_ff];
      if (cmd.scan_init) begin
         best_ff <= METRIC_MIN;
         peak_ff <= '0;
      end else if (rd_en_ff && (rd_val > best_ff)) begin
         // strict compare keeps the first maximum
         best_ff <= rd_val;
         peak_ff <= rd_idx_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff.symbol_id  <= 5'({{5{1'b0}}, cnt_ff});
         rsp_ff.id_changed <= changed_ff;
         rsp_ff.sync_light <= light_ff;
         rsp_ff.ship_data  <= !(first_ff && !synced_ff);
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hist_mem[wp_ff] <= item_ff.corr_metric;
      end
      rd_data_ff <= hist_mem[ptr_ff];
   end

endmodule

`default_nettype wire

@@ sv/frame_sync_peak_tracker.sv @@
// Top level of the frame sync peak tracker: sequencer plus datapath.
// Depends on fspt_pkg, fspt_ctrl and fspt_dpath.
//
//   channel  ports                        direction  payload
//   req      req_valid/req_ready/req_data in         mode, acquire, corr_metric
//   rsp      rsp_valid/rsp_ready/rsp_data out        symbol_id, id_changed,
//                                                    sync_light, ship_data
//   csr      csr_we/csr_index/csr_data    in         symbols_per_frame, synced_input
//
// One item at a time. A start item gives no result.
// A bypassed or still-filling symbol passes the accept, decide and final
// steps; a symbol with a peak scan adds setup, scan, drain and eval, the scan
// reading the n entries of the frame, one per cycle, from the memory's read port.
// The next item is accepted while a result waits in the output register;
// its result stalls in the last step until that register is taken.
// Synchronous reset; the history needs no clearing pass.
`default_nettype none

module frame_sync_peak_tracker
   import fspt_pkg::*;
#(
   parameter int MAX_SYMBOLS = 32
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   fspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fspt_dpath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // an accepted item blocks the input until its work is done
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still ready right after an accept");

   // a corrected symbol id always comes with a red light
   a_change_is_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.id_changed) |-> (rsp_data.sync_light == LIGHT_RED))
      else $error("id correction without red light");

   // a start item yields no result
   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.mode) |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result produced by a start item");

   // the sequencer never issues two of push (memory write), scan_step, eval, load_rsp and start together
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.scan_step, cmd.eval, cmd.load_rsp, cmd.start}))
      else $error("overlapping datapath commands");

endmodule

`default_nettype wire
